FILE: hdl/stts_pkg.sv
package stts_pkg;

    typedef struct packed {
        logic [4:0]  path_index;
        logic [15:0] unsent_packets;
        logic [15:0] in_flight;
        logic [15:0] window_packets;
        logic [30:0] slow_start_limit;
        logic [31:0] round_trip;
        logic        usable;
        logic        throttled;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [4:0]  chosen_index;
        logic [31:0] chosen_time;
    } t_out_item;

    // classified job handed from the front part to the estimator
    typedef struct packed {
        logic        skip;        // not usable, only the last mark counts
        logic        quick;       // free window covers the whole queue
        logic [16:0] cq;          // queue left after the free window
        logic [31:0] cw;          // window after the first growth step
        logic [30:0] ss;
        logic [31:0] rtt;
        logic [4:0]  idx;
        logic        thr;
        logic        last;
    } t_job;

    localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
    localparam logic [30:0] INF_SSTHRESH = 31'h7fff_ffff;

    // ceiling log2 with clog2(0) = 0, one priority search over 33 bits
    function automatic logic [5:0] clog2_32(input logic [31:0] n);
        logic [32:0] m;
        logic [5:0]  r;
        m = {1'b0, n} - 33'd1;
        r = 6'd0;
        if (n != 32'd0) begin
            for (int i = 0; i < 33; i++) begin
                if (m[i]) begin
                    r = 6'(i + 1);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pow2_32(input logic [5:0] n);
        return (n < 6'd32) ? (32'd1 << n[4:0]) : 32'd0;
    endfunction

endpackage

FILE: hdl/shortest_transfer_time_select.sv
// shortest transfer time path selector
// in channel: one path record per item (i_in_valid / o_in_ready)
// out channel: one selection result per last-marked item (o_out_valid / i_out_ready)
// cfg channel: throttle_check bit, write while the block is idle
// a front stage classifies each record (free window, first growth step) and
// a two-entry queue hands it to the estimator sequencer
// estimates use up to two serial restoring divisions, or one division and
// then one serial square root; unusable records skip the arithmetic
// the estimator takes a new record only once through with the last one; queue hides front stage stalls
// reset: selection cleared, throttle_check set to one, no item pending
// a stalled receiver holds the result; the estimator waits at the result
// step while the front and queue keep taking items
module shortest_transfer_time_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stts_pkg::t_in_item  i_in_item,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output stts_pkg::t_out_item o_out_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic                i_cfg_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready
);
    logic           r_throttle_check;
    stts_pkg::t_job w_fjob, w_qjob;
    logic           w_fvalid, w_fready, w_qvalid, w_qready;

    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_throttle_check <= 1'b1;
        end else if (i_cfg_valid) begin
            r_throttle_check <= i_cfg_data;
        end
    end

    // front: classify
    stts_front u_front (
        .i_clk, .i_rst_n,
        .i_item (i_in_item), .i_valid (i_in_valid), .o_ready (o_in_ready),
        .o_job (w_fjob), .o_valid (w_fvalid), .i_ready (w_fready)
    );

    // short queue between the two parts
    stts_queue #(.DEPTH(2)) u_queue (
        .i_clk, .i_rst_n,
        .i_job (w_fjob), .i_valid (w_fvalid), .o_ready (w_fready),
        .o_job (w_qjob), .o_valid (w_qvalid), .i_ready (w_qready)
    );

    // back: estimate, compare, emit
    stts_back u_back (
        .i_clk, .i_rst_n,
        .i_throttle_check (r_throttle_check),
        .i_job (w_qjob), .i_valid (w_qvalid), .o_ready (w_qready),
        .o_item (o_out_item), .o_valid (o_out_valid), .i_ready (i_out_ready)
    );
endmodule

FILE: hdl/stts_front.sv
module stts_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stts_pkg::t_in_item i_item,
    input  logic               i_valid,
    output logic               o_ready,
    output stts_pkg::t_job     o_job,
    output logic               o_valid,
    input  logic               i_ready
);
    stts_pkg::t_job r_job;
    stts_pkg::t_job n_job;
    logic           r_valid;
    logic [16:0]    w_q;
    logic [16:0]    w_fc;
    logic [31:0]    w_cw;
    logic [31:0]    w_two;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_comb begin
        w_q   = {1'b0, i_item.unsent_packets} + 17'd1;
        w_fc  = (i_item.window_packets > i_item.in_flight)
              ? {1'b0, i_item.window_packets - i_item.in_flight} : 17'd0;
        w_two = {15'd0, i_item.window_packets, 1'b0};
        if (w_two <= {1'b0, i_item.slow_start_limit}) begin
            w_cw = w_two;
        end else if ({16'd0, i_item.window_packets} < {1'b0, i_item.slow_start_limit}) begin
            w_cw = {1'b0, i_item.slow_start_limit};
        end else begin
            w_cw = {16'd0, i_item.window_packets} + 32'd1;
        end
        n_job.skip  = !i_item.usable;
        n_job.cq    = (w_q > w_fc) ? (w_q - w_fc) : 17'd0;
        n_job.quick = (w_fc != 17'd0) && (w_q <= w_fc);
        n_job.cw    = w_cw;
        n_job.ss    = i_item.slow_start_limit;
        n_job.rtt   = i_item.round_trip;
        n_job.idx   = i_item.path_index;
        n_job.thr   = i_item.throttled;
        n_job.last  = i_item.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule

FILE: hdl/stts_queue.sv
module stts_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stts_pkg::t_job i_job,
    input  logic           i_valid,
    output logic           o_ready,
    output stts_pkg::t_job o_job,
    output logic           o_valid,
    input  logic           i_ready
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    stts_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_ready = (r_cnt != AW'(0) + (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end
endmodule

FILE: hdl/stts_back.sv
module stts_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_throttle_check,
    input  stts_pkg::t_job      i_job,
    input  logic                i_valid,
    output logic                o_ready,
    output stts_pkg::t_out_item o_item,
    output logic                o_valid,
    input  logic                i_ready
);
    typedef enum logic [3:0] {
        S_IDLE, S_DIV1, S_LOG1, S_DIV2, S_SLOW, S_MUL1, S_CA_PRE,
        S_SQRT, S_CA_MUL, S_CA_END, S_MUL_RS, S_FINISH, S_EMIT
    } t_state;

    t_state         r_state, n_state;
    stts_pkg::t_job r_job;
    logic [31:0]    r_tt, r_rmax, r_pmax, r_cq, r_cw, r_t;
    logic [31:0]    r_num, r_den, r_quo, r_rem;
    logic [5:0]     r_step;
    logic [31:0]    r_op, r_res, r_bit;
    logic [31:0]    r_least;
    logic [4:0]     r_lidx;
    logic           r_lthr, r_have;
    logic           r_ovalid;
    stts_pkg::t_out_item r_out;

    logic [32:0]    w_rem2;
    logic [31:0]    w_half;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_out;
    assign w_half  = r_job.rtt >> 1;
    assign w_rem2  = {r_rem, r_num[31]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_DIV1;
            default:  n_state = r_state;
        endcase
    end

    // sequencer; the arithmetic of every step kept in this one clocked block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_least  <= stts_pkg::ALL_ONES;
            r_lidx   <= '0;
            r_lthr   <= 1'b0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job  <= i_job;
                        r_cq   <= {15'd0, i_job.cq};
                        r_cw   <= i_job.cw;
                        r_tt   <= i_job.rtt;
                        r_rmax <= stts_pkg::ALL_ONES;
                        r_pmax <= stts_pkg::ALL_ONES;
                        if (i_job.skip) begin
                            r_state <= S_EMIT;
                        end else if (i_job.quick) begin
                            r_t     <= i_job.rtt >> 1;
                            r_state <= S_FINISH;
                        end else if (i_job.ss != stts_pkg::INF_SSTHRESH) begin
                            r_num   <= {1'b0, i_job.ss};
                            r_den   <= i_job.cw;
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= S_DIV1;
                        end else begin
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_DIV1, S_DIV2: begin
                    // restoring division, one quotient bit a cycle
                    if (r_den == 32'd0) begin
                        r_quo  <= stts_pkg::ALL_ONES;
                        r_step <= 6'd32;
                    end else begin
                        if (w_rem2 >= {1'b0, r_den}) begin
                            r_rem <= 32'(w_rem2 - {1'b0, r_den});
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= w_rem2[31:0];
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                        r_num  <= r_num << 1;
                        r_step <= r_step + 6'd1;
                    end
                    if (r_step == 6'd32) begin
                        if (r_state == S_DIV1) begin
                            r_rmax  <= {26'd0, stts_pkg::clog2_32(r_quo)};
                            r_state <= S_LOG1;
                        end else begin
                            r_rmax  <= r_rmax; // rs kept in r_t below
                            r_t     <= {26'd0, stts_pkg::clog2_32(r_quo + 32'd1)};
                            r_state <= S_MUL_RS;
                        end
                    end
                end
                S_LOG1: begin
                    r_pmax  <= r_cw * (stts_pkg::pow2_32(r_rmax[5:0]) - 32'd1);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    if (r_cq <= r_pmax) begin
                        r_num   <= r_cq;
                        r_den   <= r_cw;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV2;
                    end else if (r_cw < {1'b0, r_job.ss}) begin
                        r_t     <= r_cw * stts_pkg::pow2_32(r_rmax[5:0]);
                        r_state <= S_SLOW;
                    end else begin
                        r_state <= S_CA_PRE;
                    end
                end
                S_SLOW: begin
                    // r_t holds cmax
                    r_cq <= r_cq - r_pmax;
                    r_tt <= r_tt + r_rmax * r_job.rtt;
                    r_cw <= {1'b0, r_job.ss};
                    if (r_t < {1'b0, r_job.ss}) begin
                        if ((r_cq - r_pmax) > r_t) begin
                            r_cq    <= r_cq - r_pmax - r_t;
                            r_tt    <= r_tt + r_rmax * r_job.rtt + r_job.rtt;
                            r_state <= S_CA_PRE;
                        end else begin
                            r_t     <= r_tt + r_rmax * r_job.rtt + w_half;
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_state <= S_CA_PRE;
                    end
                end
                S_CA_PRE: begin
                    // radicand (2cw+1)^2 + 8cq, wrapping
                    r_op    <= ({r_cw[30:0], 1'b0} + 32'd1) * ({r_cw[30:0], 1'b0} + 32'd1)
                             + {r_cq[28:0], 3'b000};
                    r_res   <= '0;
                    r_bit   <= 32'h4000_0000;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_bit == 32'd0) begin
                        r_t     <= (32'd0 - ({r_cw[30:0], 1'b0} - 32'd1) + r_res) >> 1;
                        r_state <= S_CA_MUL;
                    end else if (r_bit > r_op && r_res == 32'd0) begin
                        r_bit <= r_bit >> 2;
                    end else begin
                        if (r_op >= r_res + r_bit) begin
                            r_op  <= r_op - (r_res + r_bit);
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_CA_MUL: begin
                    // r_t = rca; r_pmax reused for pca
                    r_pmax  <= (r_t * ({r_cw[30:0], 1'b0} + r_t - 32'd1)) >> 1;
                    r_tt    <= r_tt + r_job.rtt * (r_t - 32'd1) + w_half;
                    r_state <= S_CA_END;
                end
                S_CA_END: begin
                    r_t     <= (r_cq > r_pmax) ? r_tt + r_job.rtt : r_tt;
                    r_state <= S_FINISH;
                end
                S_MUL_RS: begin
                    // r_t = rs; clamp to at least one
                    if (r_t == 32'd0) begin
                        r_t <= 32'd1;
                    end
                    r_pmax  <= r_cw * (stts_pkg::pow2_32((r_t == 32'd0) ? 6'd1 : r_t[5:0])
                             - 32'd1);
                    r_tt    <= r_tt + r_job.rtt * ((r_t == 32'd0) ? 32'd0 : r_t - 32'd1)
                             + w_half;
                    r_state <= S_CA_END;
                end
                S_FINISH: begin
                    if (r_t < r_least) begin
                        r_least <= r_t;
                        r_lidx  <= r_job.idx;
                        r_lthr  <= r_job.thr;
                        r_have  <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_job.last) begin
                        r_state <= S_IDLE;
                    end else if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        if (r_have && !(i_throttle_check && r_lthr)) begin
                            r_out <= '{found: 1'b1, chosen_index: r_lidx,
                                       chosen_time: r_least};
                        end else begin
                            r_out <= '0;
                        end
                        r_least <= stts_pkg::ALL_ONES;
                        r_lidx  <= '0;
                        r_lthr  <= 1'b0;
                        r_have  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
